/* design/assert_macros.svh */
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and quiet in reset.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define TOT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define TOT_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define TOT_ASSERT(lbl, prop)
`define TOT_ASSERT_NEVER(lbl, cond)
`endif
`endif

/* design/tot_pkg.sv */
// -----------------------------------------------------------------------------
// Timestamp ordered table package
// Shared widths, codes and types for the table and its cells.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tot_pkg;
  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned HANDLE_W = 32;

  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_LOOKUP   = 3'd1,
    OP_POP      = 3'd2,
    OP_PURGE    = 3'd3,
    OP_CLEAR    = 3'd4,
    OP_LIST     = 3'd5,
    OP_NEWEST   = 3'd6,
    OP_DEADLINE = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DROPPED  = 3'd1,
    ST_TOO_LATE = 3'd2,
    ST_DUP      = 3'd3,
    ST_NONE     = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CFG_DROP_FIRST = 2'd0,
    CFG_MAX_WAIT   = 2'd1,
    CFG_MIN_WAIT   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_TAKE_NEW,
    CELL_TAKE_PREV,
    CELL_TAKE_NEXT,
    CELL_TAKE_HEAD
  } cell_cmd_e;

  typedef struct packed {
    logic [TIME_W-1:0]   tstamp;
    logic [HANDLE_W-1:0] hdl;
  } entry_t;

  typedef struct packed {
    logic [TIME_W-1:0] key;
    logic [TIME_W-1:0] rstart;
    logic [TIME_W-1:0] rend;
  } cell_keys_t;

  typedef struct packed {
    logic gt_key;
    logic eq_key;
    logic le_end;
    logic gt_start;
  } cell_flags_t;
endpackage

/* design/tot_cell.sv */
// -----------------------------------------------------------------------------
// Table cell
// Holds one entry, loads from its neighbors, the head cell or the new entry, compares keys.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tot_cell import tot_pkg::*; (
  input  logic        clk_i,
  input  cell_cmd_e   cmd_i,
  input  entry_t      new_i,
  input  entry_t      prev_i,
  input  entry_t      next_i,
  input  entry_t      head_i,
  input  cell_keys_t  keys_i,
  output entry_t      entry_o,
  output cell_flags_t flags_o
);
  entry_t entry_q, entry_d;

  always_comb begin
    unique case (cmd_i)
      CELL_TAKE_NEW:  entry_d = new_i;
      CELL_TAKE_PREV: entry_d = prev_i;
      CELL_TAKE_NEXT: entry_d = next_i;
      CELL_TAKE_HEAD: entry_d = head_i;
      default:        entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o          = entry_q;
  assign flags_o.gt_key   = entry_q.tstamp >  keys_i.key;
  assign flags_o.eq_key   = entry_q.tstamp == keys_i.key;
  assign flags_o.le_end   = entry_q.tstamp <= keys_i.rend;
  assign flags_o.gt_start = entry_q.tstamp >  keys_i.rstart;
endmodule

/* design/timestamp_ordered_table.sv */
// -----------------------------------------------------------------------------
// Timestamp ordered table
// Sorted chain of entry cells with add, lookup, pop, purge, clear, range, newest and deadline.
// -----------------------------------------------------------------------------
//  Channel  Direction  Handshake               Payload
//  in       input      in_valid_i/in_stall_o   operation, time, handle, range
//  out      output     out_valid_o/out_stall_i status, found, handle, times, last, count
//  cfg      input      cfg_we_i                cfg_index_i, cfg_data_i
//
// One item at a time. A single-result operation goes through the execute state and
// loads its output beat in the emit state; purge first drops entries up to the key.
// A range listing decodes, then rotates the chain one entry a cycle while not stalled.
// Reset clears count and processed time; entry contents stay undefined.
// A stalled output beat holds the walk or the final beat until it is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module timestamp_ordered_table import tot_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          operation_i,
  input  logic [TIME_W-1:0]   time_stamp_i,
  input  logic [HANDLE_W-1:0] handle_i,
  input  logic [TIME_W-1:0]   range_start_i,
  input  logic [TIME_W-1:0]   range_end_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          status_o,
  output logic                found_o,
  output logic [HANDLE_W-1:0] handle_out_o,
  output logic [TIME_W-1:0]   time_out_o,
  output logic                last_of_run_o,
  output logic [CNT_W-1:0]    entry_count_o,
  output logic [TIME_W-1:0]   oldest_time_o,
  output logic [TIME_W-1:0]   newest_time_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [TIME_W-1:0]   cfg_data_i
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_PURGE = 3'd2;
  localparam logic [2:0] S_LIST  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state_q, state_d;
  op_e op_q;
  logic [TIME_W-1:0] key_q, rs_q, re_q;
  logic [HANDLE_W-1:0] hdl_q;
  logic [CNT_W-1:0] cnt_q, cnt_d, k_q, k_d;
  logic [TIME_W-1:0] pt_q, pt_d;
  logic pv_q, pv_d;
  logic drop_en_q;
  logic [TIME_W-1:0] max_wait_q, min_wait_q;
  status_e res_st_q, res_st_d;
  logic res_fnd_q, res_fnd_d, any_q, any_d;
  logic [HANDLE_W-1:0] res_h_q, res_h_d;
  logic [TIME_W-1:0] res_t_q, res_t_d;
  logic [TIME_W-1:0] snap_old_q, snap_old_d, snap_new_q, snap_new_d;

  logic out_valid_q, out_valid_d, out_load;
  logic [2:0] st_out_q, st_out_d;
  logic fnd_out_q, fnd_out_d, last_out_q, last_out_d;
  logic [HANDLE_W-1:0] h_out_q, h_out_d;
  logic [TIME_W-1:0] t_out_q, t_out_d, old_out_q, old_out_d, new_out_q, new_out_d;
  logic [CNT_W-1:0] cnt_out_q, cnt_out_d;

  entry_t      cells [TABLE_DEPTH];
  cell_flags_t flags [TABLE_DEPTH];
  cell_cmd_e   cmds  [TABLE_DEPTH];
  cell_keys_t  keys;
  entry_t      new_entry;

  logic [TABLE_DEPTH:0] occ, le;
  logic [TABLE_DEPTH-1:0] gt_occ, eq_hit, inr, new_sel, last_sel;
  logic [HANDLE_W-1:0] look_h;
  logic [TIME_W-1:0] look_t, newest_sel_t, last_t, oldest_live, newest_live;
  logic newest_gt_start;
  logic in_accept, out_free;
  logic [TIME_W-1:0] dl_diff, dl_sat, dl_base;
  logic [TIME_W:0] dl_sum;
  logic dl_have;

  assign keys      = '{key: key_q, rstart: rs_q, rend: re_q};
  assign new_entry = '{tstamp: key_q, hdl: hdl_q};

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    tot_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmds[g]),
      .new_i   (new_entry),
      .prev_i  (cells[(g == 0) ? 0 : g - 1]),
      .next_i  (cells[(g == TABLE_DEPTH - 1) ? g : g + 1]),
      .head_i  (cells[0]),
      .keys_i  (keys),
      .entry_o (cells[g]),
      .flags_o (flags[g])
    );
  end

  always_comb begin
    occ = '0;
    le  = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      occ[i]    = CNT_W'(i) < cnt_q;
      le[i]     = occ[i] && flags[i].le_end;
      gt_occ[i] = occ[i] && flags[i].gt_key;
      eq_hit[i] = occ[i] && flags[i].eq_key;
      inr[i]    = le[i] && flags[i].gt_start;
    end
    look_h = '0;
    look_t = '0;
    newest_sel_t = '0;
    newest_gt_start = 1'b0;
    last_t = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      new_sel[i]  = le[i] && !le[i+1];
      last_sel[i] = occ[i] && !occ[i+1];
      look_h = look_h | ({HANDLE_W{eq_hit[i]}} & cells[i].hdl);
      look_t = look_t | ({TIME_W{eq_hit[i]}} & cells[i].tstamp);
      newest_sel_t = newest_sel_t | ({TIME_W{new_sel[i]}} & cells[i].tstamp);
      newest_gt_start = newest_gt_start | (new_sel[i] && flags[i].gt_start);
      last_t = last_t | ({TIME_W{last_sel[i]}} & cells[i].tstamp);
    end
  end

  assign oldest_live = (cnt_q != '0) ? cells[0].tstamp : '1;
  assign newest_live = (cnt_q != '0) ? last_t : (pv_q ? pt_q : '0);

  // Deadline: current time less the longest wait, raised to base plus min wait.
  assign dl_diff = (key_q >= max_wait_q) ? key_q - max_wait_q : '0;
  assign dl_have = (cnt_q != '0) || pv_q;
  assign dl_base = (cnt_q != '0) ? last_t : pt_q;
  assign dl_sum  = {1'b0, dl_base} + {1'b0, min_wait_q};
  assign dl_sat  = dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];

  assign in_stall_o = state_q != S_IDLE;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    pt_d = pt_q;
    pv_d = pv_q;
    k_d = k_q;
    any_d = any_q;
    res_st_d = res_st_q;
    res_fnd_d = res_fnd_q;
    res_h_d = res_h_q;
    res_t_d = res_t_q;
    snap_old_d = snap_old_q;
    snap_new_d = snap_new_q;
    out_load = 1'b0;
    st_out_d = st_out_q;
    fnd_out_d = fnd_out_q;
    h_out_d = h_out_q;
    t_out_d = t_out_q;
    last_out_d = last_out_q;
    cnt_out_d = cnt_out_q;
    old_out_d = old_out_q;
    new_out_d = new_out_q;
    for (int i = 0; i < TABLE_DEPTH; i++) cmds[i] = CELL_HOLD;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d   = S_EMIT;
        res_st_d  = ST_OK;
        res_fnd_d = 1'b0;
        res_h_d   = '0;
        res_t_d   = '0;
        unique case (op_q)
          OP_ADD: begin
            res_t_d = key_q;
            priority if (drop_en_q && !pv_q) begin
              res_st_d = ST_DROPPED;
              pt_d = key_q;
              pv_d = 1'b1;
            end else if (pv_q && key_q <= pt_q) begin
              res_st_d = ST_TOO_LATE;
            end else if (|eq_hit) begin
              res_st_d = ST_DUP;
            end else if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
              res_st_d = ST_FULL;
            end else begin
              // Cells newer than the key move up one place; the gap takes the entry.
              for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (i > 0 && gt_occ[(i > 0) ? i - 1 : 0]) begin
                  cmds[i] = CELL_TAKE_PREV;
                end else if (gt_occ[i] || CNT_W'(i) == cnt_q) begin
                  cmds[i] = CELL_TAKE_NEW;
                end
              end
              cnt_d = cnt_q + 1'b1;
            end
          end
          OP_LOOKUP: begin
            if (|eq_hit) begin
              res_fnd_d = 1'b1;
              res_h_d = look_h;
              res_t_d = look_t;
            end else begin
              res_st_d = ST_NONE;
            end
          end
          OP_POP: begin
            if (cnt_q == '0) begin
              res_st_d = ST_NONE;
            end else begin
              for (int i = 0; i < TABLE_DEPTH - 1; i++) cmds[i] = CELL_TAKE_NEXT;
              cnt_d = cnt_q - 1'b1;
              pt_d = cells[0].tstamp;
              pv_d = 1'b1;
              res_fnd_d = 1'b1;
              res_h_d = cells[0].hdl;
              res_t_d = cells[0].tstamp;
            end
          end
          OP_PURGE: begin
            any_d = 1'b0;
            state_d = S_PURGE;
          end
          OP_CLEAR: begin
            cnt_d = '0;
            pt_d = '0;
            pv_d = 1'b0;
          end
          OP_LIST: begin
            if (|inr) begin
              snap_old_d = oldest_live;
              snap_new_d = newest_live;
              k_d = '0;
              state_d = S_LIST;
            end else begin
              res_st_d = ST_NONE;
            end
          end
          OP_NEWEST: begin
            if ((|le) && newest_gt_start) begin
              res_fnd_d = 1'b1;
              res_t_d = newest_sel_t;
            end else begin
              res_st_d = ST_NONE;
            end
          end
          default: begin
            res_fnd_d = 1'b1;
            res_t_d = (dl_have && dl_sat > dl_diff) ? dl_sat : dl_diff;
          end
        endcase
      end
      S_PURGE: begin
        if (cnt_q != '0 && !flags[0].gt_key) begin
          for (int i = 0; i < TABLE_DEPTH - 1; i++) cmds[i] = CELL_TAKE_NEXT;
          cnt_d = cnt_q - 1'b1;
          pt_d = cells[0].tstamp;
          pv_d = 1'b1;
          any_d = 1'b1;
        end else begin
          res_st_d = ST_OK;
          res_fnd_d = any_q;
          res_h_d = '0;
          res_t_d = any_q ? pt_q : '0;
          state_d = S_EMIT;
        end
      end
      S_LIST: begin
        // The occupied cells rotate once around; each hit leaves from the head.
        if (!inr[0] || out_free) begin
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (CNT_W'(i) == cnt_q - 1'b1) cmds[i] = CELL_TAKE_HEAD;
            else if (CNT_W'(i) < cnt_q) cmds[i] = CELL_TAKE_NEXT;
          end
          if (inr[0]) begin
            out_load = 1'b1;
            st_out_d = ST_OK;
            fnd_out_d = 1'b1;
            h_out_d = '0;
            t_out_d = cells[0].tstamp;
            last_out_d = !((k_q + 1'b1 < cnt_q) && inr[1]);
            cnt_out_d = cnt_q;
            old_out_d = snap_old_q;
            new_out_d = snap_new_q;
          end
          k_d = k_q + 1'b1;
          if (k_q == cnt_q - 1'b1) state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          st_out_d = res_st_q;
          fnd_out_d = res_fnd_q;
          h_out_d = res_h_q;
          t_out_d = res_t_q;
          last_out_d = 1'b1;
          cnt_out_d = cnt_q;
          old_out_d = oldest_live;
          new_out_d = newest_live;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      pt_q <= '0;
      pv_q <= 1'b0;
      out_valid_q <= 1'b0;
      drop_en_q <= 1'b0;
      max_wait_q <= '0;
      min_wait_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      pt_q <= pt_d;
      pv_q <= pv_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_DROP_FIRST: drop_en_q <= cfg_data_i[0];
          CFG_MAX_WAIT:   max_wait_q <= cfg_data_i;
          CFG_MIN_WAIT:   min_wait_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= op_e'(operation_i);
      key_q <= time_stamp_i;
      hdl_q <= handle_i;
      rs_q  <= range_start_i;
      re_q  <= range_end_i;
    end
    k_q <= k_d;
    any_q <= any_d;
    res_st_q <= res_st_d;
    res_fnd_q <= res_fnd_d;
    res_h_q <= res_h_d;
    res_t_q <= res_t_d;
    snap_old_q <= snap_old_d;
    snap_new_q <= snap_new_d;
    st_out_q <= st_out_d;
    fnd_out_q <= fnd_out_d;
    h_out_q <= h_out_d;
    t_out_q <= t_out_d;
    last_out_q <= last_out_d;
    cnt_out_q <= cnt_out_d;
    old_out_q <= old_out_d;
    new_out_q <= new_out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = st_out_q;
  assign found_o       = fnd_out_q;
  assign handle_out_o  = h_out_q;
  assign time_out_o    = t_out_q;
  assign last_of_run_o = last_out_q;
  assign entry_count_o = cnt_out_q;
  assign oldest_time_o = old_out_q;
  assign newest_time_o = new_out_q;

  `TOT_ASSERT_NEVER(a_count_bound, cnt_q > CNT_W'(TABLE_DEPTH))
  `TOT_ASSERT(a_accept_leaves_idle, in_accept |=> state_q == S_EXEC)
  `TOT_ASSERT(a_list_nonempty, (state_q == S_LIST) |-> (cnt_q != '0 && k_q < cnt_q))
endmodule
